FILE: src/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants of the sorted list
// Operation and status codes, and the command that is broadcast to every cell.
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int SLI_CAPACITY = 16;
	localparam int SLI_VAL_W    = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_POP    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Command broadcast to all cells in the cycle a request is accepted
	typedef struct packed {
		logic                 ins;   // insert that fits
		logic                 del;   // delete of a value that is present
		logic                 pop;   // pop on a non-empty list
		logic [SLI_VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

FILE: src/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Compares its value with the broadcast operand and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic                          clk,
	input  logic                          en,
	input  sli_pkg::cell_cmd_t            cmd,
	input  logic                          occ,        // slot holds a stored value
	input  logic                          left_lt,    // left neighbor is below operand
	input  logic [sli_pkg::SLI_VAL_W-1:0] left_val,
	input  logic [sli_pkg::SLI_VAL_W-1:0] right_val,
	output logic                          lt,
	output logic                          hit,        // first slot equal to operand
	output logic [sli_pkg::SLI_VAL_W-1:0] val,
	output logic [sli_pkg::SLI_VAL_W-1:0] val_next
);
	import sli_pkg::*;

	logic [SLI_VAL_W-1:0] val_q;

	assign val = val_q;
	assign lt  = occ && ($signed(val_q) < $signed(cmd.value));
	assign hit = occ && !lt && left_lt && (val_q == cmd.value);

	always_comb begin
		val_next = val_q;
		if (cmd.ins) begin
			// open a gap at the first slot not below the operand
			if (!lt) begin
				val_next = left_lt ? cmd.value : left_val;
			end
		end else if (cmd.del) begin
			if (!lt) begin
				val_next = right_val;
			end
		end else if (cmd.pop) begin
			val_next = right_val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= val_next;
		end
	end

endmodule

FILE: src/sorted_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top: bounded sorted list of signed values
// Insert, delete by value and pop smallest over a row of compare-and-shift
// cells; one result per request with status, removed value, count and minimum.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | value[31:0]                                     | op[1:0]
//  m_      | out | status[1:0] removed_value[31:0] entry_count[4:0] | -
//          |     | smallest[31:0] smallest_valid                    |
//
// One request per cycle while the output is not stalled: every cell compares and shifts in the
// cycle the request is accepted, and the result lands in the output register.
// arst_n clears the count and the output valid; cell contents need no reset.
// A stalled result holds; s_tready stays high while m_tready takes it.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_top #(
	parameter int CAPACITY = sli_pkg::SLI_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // status, removed_value, entry_count,
	                               // smallest, smallest_valid
);
	import sli_pkg::*;

	localparam int CntW = $clog2(CAPACITY + 1);

	logic [CntW-1:0]      count_q;
	logic [CntW-1:0]      count_next;
	logic                 accept;
	op_t                  op;
	cell_cmd_t            cmd;
	status_t              status;
	logic [SLI_VAL_W-1:0] removed;
	logic                 empty;
	logic                 full;
	logic                 found;

	logic [CAPACITY-1:0]  occ;
	logic [CAPACITY-1:0]  lt;
	logic [CAPACITY-1:0]  hit;
	logic [SLI_VAL_W-1:0] val      [CAPACITY];
	logic [SLI_VAL_W-1:0] val_next [CAPACITY];

	logic                 out_valid_q;
	status_t              status_q;
	logic [SLI_VAL_W-1:0] removed_q;
	logic [4:0]           entry_count_q;
	logic [SLI_VAL_W-1:0] smallest_q;
	logic                 smallest_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CntW'(CAPACITY));
	assign found    = |hit;

	always_comb begin
		cmd.ins    = accept && (op == OP_INSERT) && !full;
		cmd.del    = accept && (op == OP_DELETE) && !empty && found;
		cmd.pop    = accept && (op == OP_POP) && !empty;
		cmd.value  = s_tdata;
		status     = ST_OK;
		removed    = '0;
		count_next = count_q;
		case (op)
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOTFOUND;
				end else begin
					removed    = s_tdata;
					count_next = count_q - 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					removed    = val[0];
					count_next = count_q - 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Row of cells; slot 0 holds the smallest value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                 left_lt;
		logic [SLI_VAL_W-1:0] left_val;
		logic [SLI_VAL_W-1:0] right_val;

		assign occ[i] = (CntW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_lt  = 1'b1;
			assign left_val = s_tdata;
		end else begin : g_body
			assign left_lt  = lt[i-1];
			assign left_val = val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_val = val[i];
		end else begin : g_inner
			assign right_val = val[i+1];
		end

		sli_cell u_cell (
			.clk       (clk),
			.en        (accept),
			.cmd       (cmd),
			.occ       (occ[i]),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_val (right_val),
			.lt        (lt[i]),
			.hit       (hit[i]),
			.val       (val[i]),
			.val_next  (val_next[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q         <= status;
			removed_q        <= removed;
			entry_count_q    <= 5'(count_next);
			smallest_valid_q <= (count_next != '0);
			smallest_q       <= (count_next != '0) ? val_next[0] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {smallest_valid_q, smallest_q, entry_count_q, removed_q, status_q};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the sorted list insert/delete block
// Drives insert, delete and pop requests over the stream input, keeps its own
// ordered list to work out each result, and compares every returned field.
// ----------------------------------------------------------------------------
module tb;
	import sli_pkg::*;

	localparam int LIST_DEPTH   = SLI_CAPACITY;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct {
		status_t            status;
		logic signed [31:0] removed;
		logic [4:0]         count;
		logic signed [31:0] smallest;
		logic               smallest_valid;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;

	logic signed [31:0] list_model[$];
	list_result_t       pending_results[$];
	list_result_t       want;

	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int rcv_hold_left = 0;
	int errors        = 0;
	int requests_sent = 0;
	int results_seen  = 0;
	int full_hits     = 0;
	int cycle_count   = 0;

	sorted_list_insert_delete_top #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Apply one request to the list copy and return the result it should give
	function automatic list_result_t apply_list_op(op_t op, logic signed [31:0] v);
		list_result_t r;
		int pos;
		r.status = ST_OK;
		r.removed = '0;
		pos = 0;
		case (op)
		OP_INSERT: begin
			if (list_model.size() >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				while (pos < list_model.size() && list_model[pos] < v)
					pos++;
				list_model.insert(pos, v);
			end
		end
		OP_DELETE: begin
			if (list_model.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				while (pos < list_model.size() && list_model[pos] != v)
					pos++;
				if (pos >= list_model.size()) begin
					r.status = ST_NOTFOUND;
				end else begin
					r.removed = list_model[pos];
					list_model.delete(pos);
				end
			end
		end
		OP_POP: begin
			if (list_model.size() == 0)
				r.status = ST_EMPTY;
			else
				r.removed = list_model.pop_front();
		end
		default: ;
		endcase
		r.count = 5'(list_model.size());
		r.smallest = (list_model.size() > 0) ? list_model[0] : '0;
		r.smallest_valid = (list_model.size() > 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endfunction

	// Result checker: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
				check_field("removed_value", want.removed, m_tdata[33:2]);
				check_field("entry_count", 32'(want.count), 32'(m_tdata[38:34]));
				check_field("smallest", want.smallest, m_tdata[70:39]);
				check_field("smallest_valid", 32'(want.smallest_valid), 32'(m_tdata[71]));
				results_seen++;
			end
		end
	end

	// Result receiver: long hold-off first, otherwise random stalls
	always @(posedge clk) begin
		if (rcv_hold_left > 0) begin
			m_tready <= 1'b0;
			rcv_hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// Offer one request, wait for the handshake, then idle at random
	task automatic send_request(input op_t op, input logic signed [31:0] v);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_list_op(op, v));
		if (op == OP_INSERT && pending_results[$].status == ST_FULL)
			full_hits++;
		requests_sent++;
		gap = 0;
		while ($urandom_range(0, 99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop the request and hold until every expected result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'h8000_0000 + $urandom_range(0, 3);
		1: return 32'h7fff_ffff - $urandom_range(0, 3);
		2, 3, 4: return $urandom();
		default: return $urandom_range(0, 16) - 8;
		endcase
	endfunction

	function automatic bit in_list(logic signed [31:0] v);
		foreach (list_model[i])
			if (list_model[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic test_empty_list();
		send_request(OP_POP, 32'sd0);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_NOP, 32'hffff_ffff);
		wait_drained();
	endtask

	task automatic test_extremes();
		send_request(OP_INSERT, 32'h7fff_ffff);
		send_request(OP_INSERT, 32'h8000_0000);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, -32'sd1);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, 32'h8000_0000);
		// duplicate zeros: only the first goes
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_DELETE, 32'sd12345);
		send_request(OP_NOP, 32'h5a5a_a5a5);
		send_request(OP_POP, 32'h7fff_ffff);
		send_request(OP_DELETE, 32'h7fff_ffff);
		while (list_model.size() > 0)
			send_request(OP_POP, $urandom());
		send_request(OP_POP, 32'sd0);
		wait_drained();
	endtask

	task automatic test_capacity();
		logic signed [31:0] v;
		while (list_model.size() < LIST_DEPTH)
			send_request(OP_INSERT, pick_value());
		send_request(OP_INSERT, pick_value());
		do v = $urandom(); while (in_list(v));
		send_request(OP_DELETE, v);
		send_request(OP_DELETE, list_model[LIST_DEPTH / 2]);
		send_request(OP_INSERT, list_model[LIST_DEPTH - 2]);
		send_request(OP_INSERT, 32'sd0);
		while (list_model.size() > 0)
			send_request(OP_POP, pick_value());
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps going, so the input stalls
	task automatic test_backpressure();
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		rcv_hold_left = 60;
		repeat (24) begin
			if (list_model.size() < LIST_DEPTH && $urandom_range(0, 2) != 0)
				send_request(OP_INSERT, pick_value());
			else
				send_request(OP_POP, 32'sd0);
		end
		wait_drained();
	endtask

	// Segments alternate between filling and emptying so both ends are hit
	task automatic run_random_segment(int n, int ins_pct);
		int r;
		logic signed [31:0] v;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_request(OP_NOP, $urandom());
			end else if (r < ins_pct) begin
				send_request(OP_INSERT, pick_value());
			end else if (r < ins_pct + (100 - ins_pct) / 2) begin
				if (list_model.size() > 0 && $urandom_range(0, 3) != 0)
					v = list_model[$urandom_range(0, list_model.size() - 1)];
				else
					v = pick_value();
				send_request(OP_DELETE, v);
			end else begin
				send_request(OP_POP, $urandom());
			end
		end
	endtask

	task automatic test_random_traffic(int snd_pct, int rcv_pct);
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		for (int seg = 0; seg < 5; seg++)
			run_random_segment(45, (seg % 2 == 0) ? 80 : 20);
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_extremes();
		test_capacity();
		test_backpressure();
		test_random_traffic(0, 0);
		test_random_traffic(73, 0);
		test_random_traffic(0, 73);
		test_random_traffic(22, 22);

		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		wait_drained();
		repeat (4) @(posedge clk);

		$display("run covered %0d requests and %0d checked results, %0d refused inserts,",
			requests_sent, results_seen, full_hits);
		$display("empty and full lists, signed extremes, duplicates and stall mixes");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_results.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
